/* design/flmon_pkg.sv */
// Shared types, constants and register field helpers for the fault lifecycle monitor.
package flmon_pkg;

  localparam int TIME_W      = 32;
  localparam int DELAY_W     = 16;
  localparam int SEV_W       = 2;
  localparam int MASK_W      = 4;
  localparam int CFG_FAULTS  = 4;
  localparam int ID_W        = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 64;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 48;
  localparam int NUM_FAULTS_DEF = 4;

  // Register reset values
  localparam logic [MASK_W-1:0]        LATCH_RST = 4'd2;
  localparam logic [2*MASK_W-1:0]      SEV_RST   = 8'd174;
  localparam logic [CFG_DATA_W-1:0]    TIMES_RST = '0;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LATCH_MASK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEVERITY    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONFIRM     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAR       = 2'd3;

  localparam logic [SEV_W-1:0] SEV_ERROR = 2'd2;

  // Per-fault lifecycle
  typedef enum logic [2:0] {
    LS_INACTIVE   = 3'd0,
    LS_CONFIRMING = 3'd1,
    LS_ACTIVE     = 3'd2,
    LS_CLEARING   = 3'd3,
    LS_LATCHED    = 3'd4
  } life_t;

  // Sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_SCAN,
    ST_EMIT
  } seq_t;

  // Faults without register bits read zero
  function automatic logic cfg_latch(input logic [MASK_W-1:0] mask, input logic [ID_W-1:0] i);
    logic r;
    r = 1'b0;
    if (i < ID_W'(CFG_FAULTS)) r = mask[i[1:0]];
    return r;
  endfunction

  function automatic logic [SEV_W-1:0] cfg_sev(input logic [2*MASK_W-1:0] tbl,
                                               input logic [ID_W-1:0] i);
    logic [SEV_W-1:0] r;
    r = '0;
    if (i < ID_W'(CFG_FAULTS)) r = tbl[SEV_W*i[1:0] +: SEV_W];
    return r;
  endfunction

  function automatic logic [DELAY_W-1:0] cfg_delay(input logic [CFG_DATA_W-1:0] reg_v,
                                                   input logic [ID_W-1:0] i);
    logic [DELAY_W-1:0] r;
    r = '0;
    if (i < ID_W'(CFG_FAULTS)) r = reg_v[DELAY_W*i[1:0] +: DELAY_W];
    return r;
  endfunction

endpackage

/* design/flmon_wait_unit.sv */
// Wrap-safe deadline compare: the wait is over once now - (start + delay) is non-negative.
module flmon_wait_unit (
  input  logic [flmon_pkg::TIME_W-1:0]  now_time,
  input  logic [flmon_pkg::TIME_W-1:0]  start_time,
  input  logic [flmon_pkg::DELAY_W-1:0] delay,
  output logic                          over
);
  import flmon_pkg::*;

  logic [TIME_W-1:0] deadline;
  logic [TIME_W-1:0] diff;

  // Deadline modulo 2^32, then signed distance to it
  assign deadline = start_time + TIME_W'(delay);
  assign diff     = now_time - deadline;
  assign over     = ~diff[TIME_W-1];

endmodule

/* design/fault_lifecycle_debounce_monitor_core.sv */
// Top level of the fault lifecycle debounce monitor.
// Each input item reports one fault's raw condition and a millisecond timestamp; the
// fault steps through inactive, confirming, active, clearing and latched, with confirm
// and clear waits checked wrap-safe by one shared deadline compare unit. A small
// sequencer then scans the faults one per cycle to rebuild the active and latched masks
// and the worst active severity, and one result item follows each report. A valid
// report passes through the step state, the scan state once per fault and the emit state,
// which loads its result into the output register once that register is free; a report
// with an out-of-range fault number goes straight to the emit state and changes nothing.
// The block accepts a new item only when its sequencer is idle; a result waiting in the
// output register does not hold off the next report's processing.
module fault_lifecycle_debounce_monitor_core #(
  parameter int NUM_FAULTS = flmon_pkg::NUM_FAULTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // config write port
  input  logic                              cfg_we,
  input  logic [flmon_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [flmon_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // input items
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // fields from bit 0: fault_id[3:0], raw_fault[4], now_time[36:5], zero fill
  input  logic [flmon_pkg::IN_DATA_W-1:0]   in_tdata,
  // result items
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // fields from bit 0: id_invalid[0], active_faults[4:1], latched_faults[8:5],
  // worst_severity[10:9], update_time[42:11], error_present[43], zero fill
  output logic [flmon_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import flmon_pkg::*;

  localparam int IDX_W = (NUM_FAULTS > 1) ? $clog2(NUM_FAULTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_FAULTS - 1);

  // Configuration registers
  logic [MASK_W-1:0]     latch_mask_r;
  logic [2*MASK_W-1:0]   severity_r;
  logic [CFG_DATA_W-1:0] confirm_r;
  logic [CFG_DATA_W-1:0] clear_r;

  // Sequencer and captured report
  seq_t               state_r, state_nxt;
  logic [IDX_W-1:0]   id_r, id_nxt;
  logic               raw_r, raw_nxt;
  logic [TIME_W-1:0]  now_r, now_nxt;
  logic               invalid_r, invalid_nxt;
  logic [IDX_W-1:0]   scan_idx_r, scan_idx_nxt;

  // Per-fault state
  life_t              life_r  [NUM_FAULTS];
  life_t              life_nxt[NUM_FAULTS];
  logic [TIME_W-1:0]  start_r [NUM_FAULTS];
  logic [TIME_W-1:0]  start_nxt[NUM_FAULTS];

  // Kept aggregates and scan accumulators
  logic [MASK_W-1:0]  active_r, active_nxt;
  logic [MASK_W-1:0]  latched_r, latched_nxt;
  logic [SEV_W-1:0]   top_sev_r, top_sev_nxt;
  logic [TIME_W-1:0]  last_upd_r, last_upd_nxt;
  logic [MASK_W-1:0]  acc_act_r, acc_act_nxt;
  logic [MASK_W-1:0]  acc_lat_r, acc_lat_nxt;
  logic [SEV_W-1:0]   acc_sev_r, acc_sev_nxt;

  // Output register
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // Shared read port into the fault table
  logic [IDX_W-1:0]   rd_addr;
  life_t              rd_life;
  logic [ID_W-1:0]    rd_id;
  logic [TIME_W-1:0]  wait_start;
  logic [DELAY_W-1:0] wait_delay;
  logic               wait_over;
  logic               rel_latch;
  logic [SEV_W-1:0]   rd_sev;
  logic               in_bad_id;

  assign rd_addr   = (state_r == ST_SCAN) ? scan_idx_r : id_r;
  assign rd_life   = life_r[rd_addr];
  assign rd_id     = ID_W'(rd_addr);
  assign rd_sev    = cfg_sev(severity_r, rd_id);
  assign rel_latch = cfg_latch(latch_mask_r, rd_id);
  assign in_bad_id = (in_tdata[ID_W-1:0] >= ID_W'(NUM_FAULTS - 1) + 1'b1) &&
                     (NUM_FAULTS < 16);

  // Start of the wait: stored phase start while waiting, else the report time
  assign wait_start = (rd_life == LS_CONFIRMING || rd_life == LS_CLEARING) ?
                      start_r[rd_addr] : now_r;
  assign wait_delay = (rd_life == LS_INACTIVE || rd_life == LS_CONFIRMING) ?
                      cfg_delay(confirm_r, rd_id) : cfg_delay(clear_r, rd_id);

  flmon_wait_unit u_wait (
    .now_time   (now_r),
    .start_time (wait_start),
    .delay      (wait_delay),
    .over       (wait_over)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Next state and datapath
  always_comb begin
    life_t rel_state;
    state_nxt    = state_r;
    id_nxt       = id_r;
    raw_nxt      = raw_r;
    now_nxt      = now_r;
    invalid_nxt  = invalid_r;
    scan_idx_nxt = scan_idx_r;
    life_nxt     = life_r;
    start_nxt    = start_r;
    active_nxt   = active_r;
    latched_nxt  = latched_r;
    top_sev_nxt  = top_sev_r;
    last_upd_nxt = last_upd_r;
    acc_act_nxt  = acc_act_r;
    acc_lat_nxt  = acc_lat_r;
    acc_sev_nxt  = acc_sev_r;
    out_data_nxt = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    rel_state    = rel_latch ? LS_LATCHED : LS_INACTIVE;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          id_nxt      = in_tdata[IDX_W-1:0];
          raw_nxt     = in_tdata[ID_W];
          now_nxt     = in_tdata[ID_W+1 +: TIME_W];
          invalid_nxt = in_bad_id;
          state_nxt   = in_bad_id ? ST_EMIT : ST_STEP;
        end
      end
      ST_STEP: begin
        // One lifecycle step of the reported fault
        case (rd_life)
          LS_INACTIVE: begin
            if (raw_r) begin
              start_nxt[id_r] = now_r;
              life_nxt[id_r]  = wait_over ? LS_ACTIVE : LS_CONFIRMING;
            end
          end
          LS_CONFIRMING: begin
            if (!raw_r) life_nxt[id_r] = LS_INACTIVE;
            else if (wait_over) life_nxt[id_r] = LS_ACTIVE;
          end
          LS_ACTIVE: begin
            if (!raw_r) begin
              start_nxt[id_r] = now_r;
              life_nxt[id_r]  = wait_over ? rel_state : LS_CLEARING;
            end
          end
          LS_CLEARING: begin
            if (raw_r) life_nxt[id_r] = LS_ACTIVE;
            else if (wait_over) life_nxt[id_r] = rel_state;
          end
          default: life_nxt[id_r] = LS_LATCHED;
        endcase
        scan_idx_nxt = '0;
        acc_act_nxt  = '0;
        acc_lat_nxt  = '0;
        acc_sev_nxt  = '0;
        state_nxt    = ST_SCAN;
      end
      ST_SCAN: begin
        // Fold one fault into the masks and worst severity
        if (rd_life == LS_ACTIVE) begin
          acc_act_nxt = acc_act_r | (MASK_W'(1) << scan_idx_r);
          if (rd_sev > acc_sev_r) acc_sev_nxt = rd_sev;
        end
        if (rd_life == LS_LATCHED) begin
          acc_lat_nxt = acc_lat_r | (MASK_W'(1) << scan_idx_r);
        end
        if (scan_idx_r == LAST_IDX) begin
          active_nxt   = acc_act_nxt;
          latched_nxt  = acc_lat_nxt;
          top_sev_nxt  = acc_sev_nxt;
          last_upd_nxt = now_r;
          state_nxt    = ST_EMIT;
        end else begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end
      ST_EMIT: begin
        // Load the result once the output register is free
        if (!out_valid_r || out_tready) begin
          out_data_nxt = OUT_DATA_W'({
            ((latched_r != '0) || (top_sev_r >= SEV_ERROR)),
            last_upd_r, top_sev_r, latched_r, active_r, invalid_r});
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers and kept state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      active_r    <= '0;
      latched_r   <= '0;
      top_sev_r   <= '0;
      last_upd_r  <= '0;
      for (int i = 0; i < NUM_FAULTS; i++) life_r[i] <= LS_INACTIVE;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      active_r    <= active_nxt;
      latched_r   <= latched_nxt;
      top_sev_r   <= top_sev_nxt;
      last_upd_r  <= last_upd_nxt;
      life_r      <= life_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    id_r       <= id_nxt;
    raw_r      <= raw_nxt;
    now_r      <= now_nxt;
    invalid_r  <= invalid_nxt;
    scan_idx_r <= scan_idx_nxt;
    start_r    <= start_nxt;
    acc_act_r  <= acc_act_nxt;
    acc_lat_r  <= acc_lat_nxt;
    acc_sev_r  <= acc_sev_nxt;
    out_data_r <= out_data_nxt;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_mask_r <= LATCH_RST;
      severity_r   <= SEV_RST;
      confirm_r    <= TIMES_RST;
      clear_r      <= TIMES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LATCH_MASK: latch_mask_r <= cfg_wdata[MASK_W-1:0];
        REG_SEVERITY:   severity_r   <= cfg_wdata[2*MASK_W-1:0];
        REG_CONFIRM:    confirm_r    <= cfg_wdata;
        REG_CLEAR:      clear_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the fault lifecycle debounce monitor core.
`timescale 1ns / 1ps

module tb_top;
  import flmon_pkg::*;

  localparam int N_FAULTS    = NUM_FAULTS_DEF;
  localparam int SETTLE_CYC  = N_FAULTS + 5;
  localparam int STALL_LIMIT = 1000;

  // One expected result item
  typedef struct {
    logic              inv;
    logic [MASK_W-1:0] act;
    logic [MASK_W-1:0] lat;
    logic [SEV_W-1:0]  sev;
    logic [TIME_W-1:0] upd;
    logic              err;
  } fault_report_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  // fault_id[3:0], raw_fault[4], now_time[36:5], zero fill
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // id_invalid[0], active_faults[4:1], latched_faults[8:5], worst_severity[10:9],
  // update_time[42:11], error_present[43], zero fill
  logic [OUT_DATA_W-1:0] out_tdata;

  fault_lifecycle_debounce_monitor_core #(
    .NUM_FAULTS(N_FAULTS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // Shadow registers
  logic [MASK_W-1:0]     shadow_latch;
  logic [2*MASK_W-1:0]   shadow_sev;
  logic [CFG_DATA_W-1:0] shadow_confirm;
  logic [CFG_DATA_W-1:0] shadow_clear;

  // Shadow lifecycle state
  life_t             fault_life  [N_FAULTS];
  logic [TIME_W-1:0] phase_t0    [N_FAULTS];
  logic [MASK_W-1:0] kept_active;
  logic [MASK_W-1:0] kept_latched;
  logic [SEV_W-1:0]  kept_sev;
  logic [TIME_W-1:0] kept_time;

  fault_report_t     pending_reports[$];
  int                mismatches;
  bit                steady_flow;
  logic              raw_goal [N_FAULTS];
  logic [TIME_W-1:0] clock_ms;
  int                idle_cycles;
  int                stall_left;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Wrap-safe deadline: (now - (start + delay)) as signed is not negative
  function automatic bit deadline_met(input logic [TIME_W-1:0] now,
                                      input logic [TIME_W-1:0] start,
                                      input logic [DELAY_W-1:0] delay);
    logic [TIME_W-1:0] d;
    d = now - (start + TIME_W'(delay));
    return !d[TIME_W-1];
  endfunction

  // Advance the shadow lifecycle by one report and build the expected result
  function automatic fault_report_t predict_report(input logic [ID_W-1:0] id,
                                                   input logic raw,
                                                   input logic [TIME_W-1:0] now);
    fault_report_t     r;
    int                i;
    int                k;
    logic [DELAY_W-1:0] cdel;
    logic [DELAY_W-1:0] rdel;
    life_t             release_to;
    logic [MASK_W-1:0] a;
    logic [MASK_W-1:0] l;
    logic [SEV_W-1:0]  s;
    logic [SEV_W-1:0]  fs;
    r.inv = 1'b1;
    if (id < N_FAULTS) begin
      i = int'(id);
      r.inv = 1'b0;
      cdel = shadow_confirm[DELAY_W*i +: DELAY_W];
      rdel = shadow_clear[DELAY_W*i +: DELAY_W];
      release_to = shadow_latch[i] ? LS_LATCHED : LS_INACTIVE;
      case (fault_life[i])
        LS_INACTIVE: begin
          if (raw) begin
            fault_life[i] = LS_CONFIRMING;
            phase_t0[i] = now;
            if (deadline_met(now, now, cdel)) fault_life[i] = LS_ACTIVE;
          end
        end
        LS_CONFIRMING: begin
          if (!raw) fault_life[i] = LS_INACTIVE;
          else if (deadline_met(now, phase_t0[i], cdel)) fault_life[i] = LS_ACTIVE;
        end
        LS_ACTIVE: begin
          if (!raw) begin
            fault_life[i] = LS_CLEARING;
            phase_t0[i] = now;
            if (deadline_met(now, now, rdel)) fault_life[i] = release_to;
          end
        end
        LS_CLEARING: begin
          if (raw) fault_life[i] = LS_ACTIVE;
          else if (deadline_met(now, phase_t0[i], rdel)) fault_life[i] = release_to;
        end
        default: fault_life[i] = LS_LATCHED;
      endcase
      // rebuild the kept aggregates
      a = '0;
      l = '0;
      s = '0;
      for (k = 0; k < N_FAULTS; k++) begin
        fs = shadow_sev[SEV_W*k +: SEV_W];
        if (fault_life[k] == LS_ACTIVE) begin
          a[k] = 1'b1;
          if (fs > s) s = fs;
        end
        if (fault_life[k] == LS_LATCHED) l[k] = 1'b1;
      end
      kept_active = a;
      kept_latched = l;
      kept_sev = s;
      kept_time = now;
    end
    r.act = kept_active;
    r.lat = kept_latched;
    r.sev = kept_sev;
    r.upd = kept_time;
    r.err = (kept_latched != '0) || (kept_sev >= SEV_ERROR);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] MISMATCH %s: got %0h expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Mostly short gaps, a few long ones, none while steady_flow is set
  function automatic int pick_idle_len();
    int r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side backpressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready = 1'b0;
      stall_left--;
    end else begin
      out_tready = 1'b1;
      stall_left = pick_idle_len();
    end
  end

  // Check each accepted result item against the oldest expectation
  always @(posedge clk) begin
    fault_report_t want;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (pending_reports.size() == 0) begin
        report_mismatch("result with none expected", out_tdata[31:0], '0);
      end else begin
        want = pending_reports.pop_front();
        if (out_tdata[0] !== want.inv)
          report_mismatch("id_invalid", 32'(out_tdata[0]), 32'(want.inv));
        if (out_tdata[4:1] !== want.act)
          report_mismatch("active_faults", 32'(out_tdata[4:1]), 32'(want.act));
        if (out_tdata[8:5] !== want.lat)
          report_mismatch("latched_faults", 32'(out_tdata[8:5]), 32'(want.lat));
        if (out_tdata[10:9] !== want.sev)
          report_mismatch("worst_severity", 32'(out_tdata[10:9]), 32'(want.sev));
        if (out_tdata[42:11] !== want.upd)
          report_mismatch("update_time", out_tdata[42:11], want.upd);
        if (out_tdata[43] !== want.err)
          report_mismatch("error_present", 32'(out_tdata[43]), 32'(want.err));
      end
    end
  end

  // Watchdog on cycles without any accepted item
  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready === 1'b1) || (out_tvalid === 1'b1 && out_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  // Send one report item; returns at the edge where it was accepted
  task automatic send_report(input logic [ID_W-1:0] id, input logic raw,
                             input logic [TIME_W-1:0] now);
    int gap;
    gap = pick_idle_len();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      in_tdata = IN_DATA_W'({$urandom, $urandom});
      repeat (gap) @(negedge clk);
    end
    in_tdata = {3'b000, now, raw, id};
    in_tvalid = 1'b1;
    do @(posedge clk); while (in_tready !== 1'b1);
    pending_reports.push_back(predict_report(id, raw, now));
  endtask

  // Stop sending, let every expected result drain, then let the block settle
  task automatic wait_for_idle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    case (idx)
      REG_LATCH_MASK: shadow_latch = data[MASK_W-1:0];
      REG_SEVERITY:   shadow_sev = data[2*MASK_W-1:0];
      REG_CONFIRM:    shadow_confirm = data;
      default:        shadow_clear = data;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Full register set; narrow registers get junk above their width
  task automatic apply_config(input logic [MASK_W-1:0] latch, input logic [2*MASK_W-1:0] sev,
                              input logic [CFG_DATA_W-1:0] conf,
                              input logic [CFG_DATA_W-1:0] clr);
    logic [CFG_DATA_W-1:0] wd;
    wait_for_idle();
    wd = {$urandom, $urandom};
    wd[MASK_W-1:0] = latch;
    write_reg(REG_LATCH_MASK, wd);
    wd = {$urandom, $urandom};
    wd[2*MASK_W-1:0] = sev;
    write_reg(REG_SEVERITY, wd);
    write_reg(REG_CONFIRM, conf);
    write_reg(REG_CLEAR, clr);
  endtask

  function automatic logic [CFG_DATA_W-1:0] short_delays(input int max_ms);
    return {16'($urandom_range(0, max_ms)), 16'($urandom_range(0, max_ms)),
            16'($urandom_range(0, max_ms)), 16'($urandom_range(0, max_ms))};
  endfunction

  // Reset register values: zero delays act at once, unknown numbers change nothing
  task automatic test_reset_defaults();
    send_report(4'd0, 1'b1, 32'd0);
    send_report(4'd3, 1'b1, 32'd1);
    send_report(4'd15, 1'b1, 32'hFFFF_FFFF);
    send_report(4'd0, 1'b0, 32'd2);
    send_report(4'd3, 1'b0, 32'hFFFF_FFFE);
  endtask

  // Confirm and clear waits, aborts, bounce back, wrap and time going backwards
  task automatic test_debounce_timing();
    apply_config(4'h0, SEV_RST, {16'd3, 16'hFFFF, 16'd0, 16'd10},
                 {16'hFFFF, 16'd0, 16'd0, 16'd5});
    send_report(4'd0, 1'b1, 32'd100);
    send_report(4'd0, 1'b1, 32'd105);
    send_report(4'd0, 1'b1, 32'd110);
    send_report(4'd0, 1'b0, 32'd111);
    send_report(4'd0, 1'b1, 32'd113);
    send_report(4'd0, 1'b0, 32'd120);
    send_report(4'd0, 1'b0, 32'd125);
    send_report(4'd0, 1'b1, 32'd200);
    send_report(4'd0, 1'b0, 32'd201);
    send_report(4'd2, 1'b1, 32'hFFFF_F000);
    send_report(4'd2, 1'b1, 32'h0000_0FFF);
    send_report(4'd2, 1'b1, 32'h0000_EFFE);
    send_report(4'd2, 1'b1, 32'h0000_EFFF);
    send_report(4'd3, 1'b1, 32'd50);
    send_report(4'd3, 1'b1, 32'd40);
    send_report(4'd3, 1'b1, 32'd53);
  endtask

  // Kept severity follows a table change only at the next valid report
  task automatic test_severity_stale();
    wait_for_idle();
    write_reg(REG_SEVERITY, 64'hFF);
    send_report(4'd4, 1'b1, 32'd7);
    send_report(4'd1, 1'b0, 32'd8);
    wait_for_idle();
    write_reg(REG_SEVERITY, 64'h0);
    send_report(4'd9, 1'b0, 32'd9);
    send_report(4'd1, 1'b0, 32'd10);
  endtask

  // A latching fault sticks once released
  task automatic test_latch_sticky();
    apply_config(4'b0010, 8'hE4, '0, '0);
    send_report(4'd1, 1'b1, 32'd1000);
    send_report(4'd1, 1'b0, 32'd1001);
    send_report(4'd1, 1'b1, 32'd1002);
    send_report(4'd1, 1'b0, 32'd1003);
  endtask

  // Per-fault raw levels that hold for runs, with noise, jumps and wrong numbers
  task automatic test_random_traffic(input int n_items, input int step_max);
    logic [ID_W-1:0] id;
    logic            raw;
    int              r;
    int              k;
    clock_ms = $urandom;
    for (k = 0; k < n_items; k++) begin
      steady_flow = (k >= n_items / 3) && (k < n_items / 3 + 30);
      if (k == n_items / 2) wait_for_idle();
      r = $urandom_range(0, 99);
      if (r < 4) clock_ms = $urandom;
      else if (r < 7) clock_ms = clock_ms - $urandom_range(1, step_max);
      else clock_ms = clock_ms + $urandom_range(0, step_max);
      if ($urandom_range(0, 9) == 0) id = ID_W'($urandom_range(N_FAULTS, 15));
      else id = ID_W'($urandom_range(0, N_FAULTS - 1));
      if (id < N_FAULTS) begin
        if ($urandom_range(0, 7) == 0) raw_goal[id] = ~raw_goal[id];
        raw = raw_goal[id];
      end else begin
        raw = 1'($urandom_range(0, 1));
      end
      if ($urandom_range(0, 9) == 0) raw = ~raw;
      send_report(id, raw, clock_ms);
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    int k;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    mismatches = 0;
    steady_flow = 1'b0;
    stall_left = 0;
    shadow_latch = LATCH_RST;
    shadow_sev = SEV_RST;
    shadow_confirm = TIMES_RST;
    shadow_clear = TIMES_RST;
    for (k = 0; k < N_FAULTS; k++) begin
      fault_life[k] = LS_INACTIVE;
      phase_t0[k] = '0;
      raw_goal[k] = 1'b0;
    end
    kept_active = '0;
    kept_latched = '0;
    kept_sev = '0;
    kept_time = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_debounce_timing();
    test_severity_stale();

    apply_config(4'h0, 8'h00, '0, '0);
    test_random_traffic(150, 4);
    apply_config(4'h0, 8'hFF, '1, '1);
    test_random_traffic(150, 30000);
    apply_config(4'h0, 8'($urandom), short_delays(40), short_delays(40));
    test_random_traffic(200, 20);
    apply_config(4'h0, 8'($urandom), {$urandom, $urandom}, {$urandom, $urandom});
    test_random_traffic(150, 25000);
    test_latch_sticky();
    apply_config(4'($urandom), 8'($urandom), short_delays(30), short_delays(30));
    test_random_traffic(200, 15);
    apply_config(4'hF, 8'($urandom), short_delays(30), short_delays(30));
    test_random_traffic(200, 15);

    wait_for_idle();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
